@@ hw/rtl/serial_frame_encoder_top_macros.svh @@
// Assertion macros shared by the serial frame encoder checker.
`ifndef SERIAL_FRAME_ENCODER_TOP_MACROS_SVH
`define SERIAL_FRAME_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SFE_ASSERT_NXT_ALWAYS(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sfe_pkg.sv @@
// Shared types and character constants for the serial frame encoder.
package sfe_pkg;

  localparam logic [7:0] ChPad      = 8'h3D;
  localparam logic [7:0] ChStart    = 8'h23;
  localparam logic [7:0] ChAddrBase = 8'h61;
  localparam logic [7:0] ChCr       = 8'h0D;

  // Number of jobs the queue between front and back can hold.
  localparam int QueueDepth = 4;

  typedef enum logic {
    JOB_HEADER = 1'b0,
    JOB_GROUP  = 1'b1
  } job_kind_t;

  // One unit of work for the back end. For a header, b0 holds the address
  // character and b1 the command; for a group, b0..b2 are the three bytes.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       trailer;
  } job_t;

endpackage

@@ hw/rtl/sfe_front.sv @@
// Front end: accepts input beats, tracks frame and group state, issues jobs.
module sfe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_action,
  input  logic [7:0]    in_address,
  input  logic [7:0]    in_command,
  input  logic          in_no_payload,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  output logic          job_push,
  output sfe_pkg::job_t job_data,
  input  logic          job_ready
);

  logic       in_frame_r, in_frame_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic       accept;

  assign in_stall = !job_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_frame_nxt     = in_frame_r;
    fill_nxt         = fill_r;
    first_nxt        = first_r;
    second_nxt       = second_r;
    job_push         = 1'b0;
    job_data.kind    = sfe_pkg::JOB_GROUP;
    job_data.b0      = first_r;
    job_data.b1      = second_r;
    job_data.b2      = in_data_byte;
    job_data.trailer = in_last_byte;
    if (accept) begin
      if (!in_action) begin
        // A header always starts a fresh frame and drops any partial group.
        job_push         = 1'b1;
        job_data.kind    = sfe_pkg::JOB_HEADER;
        job_data.b0      = sfe_pkg::ChAddrBase + in_address;
        job_data.b1      = in_command;
        job_data.b2      = 8'h00;
        job_data.trailer = in_no_payload;
        in_frame_nxt     = !in_no_payload;
        fill_nxt         = 2'd0;
      end else if (in_frame_r) begin
        unique case (fill_r)
          2'd0: begin
            first_nxt = in_data_byte;
            fill_nxt  = 2'd1;
            if (in_last_byte) begin
              job_push    = 1'b1;
              job_data.b0 = in_data_byte;
              job_data.b1 = 8'h00;
              job_data.b2 = 8'h00;
            end
          end
          2'd1: begin
            second_nxt = in_data_byte;
            fill_nxt   = 2'd2;
            if (in_last_byte) begin
              job_push    = 1'b1;
              job_data.b1 = in_data_byte;
              job_data.b2 = 8'h00;
            end
          end
          default: begin
            job_push = 1'b1;
            fill_nxt = 2'd0;
          end
        endcase
        if (in_last_byte) begin
          in_frame_nxt = 1'b0;
          fill_nxt     = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      fill_r     <= 2'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

endmodule

@@ hw/rtl/sfe_queue.sv @@
// Small job queue that decouples the front end from the back end.
module sfe_queue #(
  parameter int DEPTH = sfe_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfe_pkg::job_t push_data,
  output logic          push_ready,
  input  logic          pop,
  output sfe_pkg::job_t pop_data,
  output logic          pop_valid
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  sfe_pkg::job_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CntW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ hw/rtl/sfe_back.sv @@
// Back end: turns jobs into characters, keeps the checksum, drives the output beat.
module sfe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sfe_pkg::job_t job_data,
  input  logic          job_valid,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char_out,
  output logic          out_run_last,
  output logic          out_frame_end
);

  sfe_pkg::job_t cur_r;
  logic          busy_r;
  logic [2:0]    step_r;
  logic [11:0]   sum_r, sum_nxt;
  logic          out_valid_r;
  logic [7:0]    char_r;
  logic          run_last_r, frame_end_r;

  logic       advance;
  logic [2:0] body_len, tr_idx;
  logic       counted, is_cr, is_last;
  logic [5:0] slice;
  logic [7:0] char_nxt;

  assign advance = busy_r && (!out_valid_r || !out_stall);
  assign job_pop = job_valid && (!busy_r || (advance && is_last));

  always_comb begin
    body_len = (cur_r.kind == sfe_pkg::JOB_HEADER) ? 3'd3 : 3'd4;
    tr_idx   = step_r - body_len;
    counted  = (step_r < body_len);
    is_cr    = !counted && (tr_idx == 3'd2);
    is_last  = is_cr || (!cur_r.trailer && (step_r == body_len - 3'd1));

    unique case (step_r[1:0])
      2'd0:    slice = cur_r.b0[7:2];
      2'd1:    slice = {cur_r.b0[1:0], cur_r.b1[7:4]};
      2'd2:    slice = {cur_r.b1[3:0], cur_r.b2[7:6]};
      default: slice = cur_r.b2[5:0];
    endcase

    if (counted) begin
      if (cur_r.kind == sfe_pkg::JOB_HEADER) begin
        unique case (step_r[1:0])
          2'd0:    char_nxt = sfe_pkg::ChStart;
          2'd1:    char_nxt = cur_r.b0;
          default: char_nxt = cur_r.b1;
        endcase
      end else begin
        char_nxt = sfe_pkg::ChPad + {2'b00, slice};
      end
    end else begin
      unique case (tr_idx[1:0])
        2'd0:    char_nxt = sfe_pkg::ChPad + {2'b00, sum_r[11:6]};
        2'd1:    char_nxt = sfe_pkg::ChPad + {2'b00, sum_r[5:0]};
        default: char_nxt = sfe_pkg::ChCr;
      endcase
    end

    sum_nxt = sum_r;
    if (counted) begin
      if ((cur_r.kind == sfe_pkg::JOB_HEADER) && (step_r == 3'd0)) begin
        sum_nxt = {4'h0, char_nxt};
      end else begin
        sum_nxt = sum_r + {4'h0, char_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (job_pop) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (advance) begin
        if (is_last) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur_r <= job_data;
    if (advance) begin
      char_r      <= char_nxt;
      run_last_r  <= is_last;
      frame_end_r <= is_cr;
      sum_r       <= sum_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = char_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

endmodule

@@ hw/rtl/serial_frame_encoder_top.sv @@
// Serial frame encoder: header and payload beats in, ASCII frame characters out.
//
// This block turns header and payload beats into an ASCII serial frame, one
// character per output beat. A header beat yields '#', 'a' plus the address
// and the command character, and with no_payload set also the two checksum
// characters and a carriage return. Payload bytes are gathered in groups of
// three; each full group yields four characters of six bits plus '=', and the
// byte marked last flushes the group, padded with zero bytes, and then the
// checksum and carriage return. The checksum is a 12-bit sum of every frame
// character before it and is sent as '=' plus its upper and lower six bits.
// A payload beat with no frame open yields nothing. The back end emits one
// character per cycle while the output does not stall, so a header yields three
// characters (six with its trailer), a completed group four, and a closing group
// seven; the character sequencer in the back end is what sets this rate. Input
// beats that finish no group push no job, and the input only stalls when the
// job queue of QUEUE_DEPTH entries (two or more) between the front and back
// ends is full. run_last marks the final character caused by one input beat
// and frame_end marks the carriage return.
module serial_frame_encoder_top #(
  parameter int QUEUE_DEPTH = sfe_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_address,
  input  logic [7:0] in_command,
  input  logic       in_no_payload,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_run_last,
  output logic       out_frame_end
);

  // Jobs flow from the front end through the queue to the back end.
  sfe_pkg::job_t push_job, pop_job;
  logic          push, push_ready, pop, pop_valid;

  // The front end keeps the frame-open flag and the partial group.
  sfe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_address    (in_address),
    .in_command    (in_command),
    .in_no_payload (in_no_payload),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .job_push      (push),
    .job_data      (push_job),
    .job_ready     (push_ready)
  );

  // The queue lets the front end keep taking beats while characters drain.
  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_job),
    .pop_valid  (pop_valid)
  );

  // The back end owns the checksum and the registered output beat.
  sfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_data      (pop_job),
    .job_valid     (pop_valid),
    .job_pop       (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_out  (out_char_out),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

@@ hw/rtl/sfe_checker.sv @@
// Port-level checker for the serial frame encoder, bound to the top level.
`include "serial_frame_encoder_top_macros.svh"

module sfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char_out,
  input logic       out_run_last,
  input logic       out_frame_end
);

  `SFE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_char_out) && $stable(out_run_last) && $stable(out_frame_end), "stalled output beat changed")
  `SFE_ASSERT_IMP(a_end_is_cr, clk, rst_n, out_valid && out_frame_end, out_char_out == sfe_pkg::ChCr, "frame end beat is not a carriage return")
  `SFE_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid && out_frame_end, out_run_last, "frame end beat not marked as last of its item")
  `SFE_ASSERT_NXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid, "output beat valid right after reset")

endmodule

bind serial_frame_encoder_top sfe_checker u_sfe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char_out  (out_char_out),
  .out_run_last  (out_run_last),
  .out_frame_end (out_frame_end)
);
